### src/adaptive_frequency_model_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive frequency model
// Immediate-style wrappers around concurrent assertions on i_clk / i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_FREQUENCY_MODEL_MACROS_SVH
`define ADAPTIVE_FREQUENCY_MODEL_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AFM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFM_ASSERT_IMPL(lbl, ante, cons, msg)
`define AFM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/afm_pkg.sv
// ----------------------------------------------------------------------------
// afm_pkg
// Shared widths, command codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package afm_pkg;

    localparam int OP_W            = 3;
    localparam int SYM_W           = 8;
    localparam int SUM_W           = 32;
    localparam int ALPHA_W         = 9;
    localparam int FOUND_W         = 9;
    localparam int DEF_MAX_SYMBOLS = 256;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_INC     = 3'd0,
        OP_QUERY   = 3'd1,
        OP_FIND    = 3'd2,
        OP_RESCALE = 3'd3,
        OP_FILL    = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_MARK    = 3'd6,
        OP_CHECK   = 3'd7
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic inc_wr;
        logic walk;
        logic clr;
        logic done_load;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic sym_ok;
        logic len_zero;
        logic walk_end;
        logic clr_last;
    } t_sts;

endpackage

### src/afm_ctrl.sv
// ----------------------------------------------------------------------------
// afm_ctrl
// Command sequencer: clearing sweep, decode, read-modify-write, table walk
// and result hand-off to the output register.
// ----------------------------------------------------------------------------
module afm_ctrl
    import afm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [5:0] {
        ST_CLR    = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DECODE = 6'b000100,
        ST_INC    = 6'b001000,
        ST_WALK   = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_cmd, n_clr_cmd;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state   = r_state;
        n_clr_cmd = r_clr_cmd;
        o_ctl     = '0;
        case (r_state)
            ST_CLR: begin
                o_ctl.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state   = r_clr_cmd ? ST_DONE : ST_IDLE;
                    n_clr_cmd = 1'b0;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_ctl.decode = 1'b1;
                case (i_sts.op)
                    OP_INC:   n_state = i_sts.sym_ok ? ST_INC : ST_DONE;
                    OP_QUERY: n_state = i_sts.sym_ok ? ST_WALK : ST_DONE;
                    OP_MARK:  n_state = ST_DONE;
                    OP_CLEAR: begin
                        n_state   = ST_CLR;
                        n_clr_cmd = 1'b1;
                    end
                    default:  n_state = i_sts.len_zero ? ST_DONE : ST_WALK;
                endcase
            end
            ST_INC: begin
                o_ctl.inc_wr = 1'b1;
                n_state      = ST_DONE;
            end
            ST_WALK: begin
                o_ctl.walk = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_ctl.done_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_ctl.done_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/afm_datapath.sv
// ----------------------------------------------------------------------------
// afm_datapath
// Count memory, walk counters, cumulative accumulator, total and results.
// ----------------------------------------------------------------------------
module afm_datapath
    import afm_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    output t_sts               o_sts,
    input  logic [OP_W-1:0]    i_command,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic [SUM_W-1:0]   i_target,
    input  logic               i_cfg_we,
    input  logic [ALPHA_W-1:0] i_cfg_data,
    output logic [SUM_W-1:0]   o_cum_low,
    output logic [SUM_W-1:0]   o_cum_high,
    output logic [SUM_W-1:0]   o_total,
    output logic [FOUND_W-1:0] o_found_symbol,
    output logic               o_all_ones,
    output logic               o_error
);

    localparam int IDX_W = $clog2(MAX_SYMBOLS);
    localparam int CNT_W = IDX_W + 1;
    localparam int LW    = (CNT_W > ALPHA_W) ? CNT_W : ALPHA_W;
    localparam int ACC_W = SUM_W + 1;
    localparam int HI_W  = SUM_W + 2;

    // accumulator caps at 2**SUM_W: anything past that is above every target
    localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {SUM_W{1'b0}}};
    localparam logic [HI_W-1:0]  SUM_MAX = {2'b00, {SUM_W{1'b1}}};

    function automatic logic [SUM_W-1:0] sat_sum(input logic [HI_W-1:0] v);
        return (v > SUM_MAX) ? {SUM_W{1'b1}} : v[SUM_W-1:0];
    endfunction

    logic [COUNT_WIDTH-1:0] r_mem [MAX_SYMBOLS];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    t_op                r_op;
    logic [SYM_W-1:0]   r_sym;
    logic [SUM_W-1:0]   r_target;
    logic [ALPHA_W-1:0] r_alpha;
    logic [SUM_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_issue;
    logic               r_pv;
    logic [IDX_W-1:0]   r_pidx;
    logic [ACC_W-1:0]   r_acc;
    logic [SUM_W-1:0]   r_cl, r_ch;
    logic [FOUND_W-1:0] r_found;
    logic               r_ones, r_err;

    logic [SUM_W-1:0]   r_o_cl, r_o_ch, r_o_total;
    logic [FOUND_W-1:0] r_o_found;
    logic               r_o_ones, r_o_err;

    logic [LW-1:0]      alpha_l, max_l, eff_l, sym_l, sym_p1, pidx_l;
    logic [CNT_W-1:0]   eff, len, pidx_p1;
    logic [IDX_W-1:0]   sym_idx, rd_addr, wr_addr;
    logic               sym_ok, issuing, is_last, hit, cnt_full, rd_zero;
    logic [HI_W-1:0]    d_hi, acc_hi, hi, tgt_hi;
    logic [ACC_W-1:0]   hi_cap;
    logic [SUM_W-1:0]   total_inc;
    logic               wr_en;
    logic [COUNT_WIDTH-1:0] wr_data;

    assign alpha_l = LW'(r_alpha);
    assign max_l   = LW'(MAX_SYMBOLS);
    assign eff_l   = (alpha_l < max_l) ? alpha_l : max_l;
    assign eff     = eff_l[CNT_W-1:0];
    assign sym_l   = LW'(r_sym);
    assign sym_ok  = sym_l < eff_l;
    assign sym_p1  = sym_l + LW'(1);
    assign sym_idx = sym_l[IDX_W-1:0];
    assign len     = (r_op == OP_QUERY) ? sym_p1[CNT_W-1:0] : eff;
    assign pidx_l  = LW'(r_pidx);
    assign pidx_p1 = {1'b0, r_pidx} + CNT_W'(1);
    assign is_last = (pidx_p1 == len);
    assign issuing = (r_issue < len);

    assign d_hi    = HI_W'(r_rd_data);
    assign acc_hi  = HI_W'(r_acc);
    assign hi      = acc_hi + d_hi;
    assign tgt_hi  = HI_W'(r_target);
    assign hit     = (acc_hi <= tgt_hi) && (tgt_hi <= hi);
    assign hi_cap  = (hi >= HI_W'(ACC_CAP)) ? ACC_CAP : hi[ACC_W-1:0];

    assign cnt_full  = (r_rd_data == {COUNT_WIDTH{1'b1}});
    assign rd_zero   = (r_rd_data == '0);
    assign total_inc = (r_total == {SUM_W{1'b1}}) ? r_total : r_total + SUM_W'(1);

    assign o_sts.op       = r_op;
    assign o_sts.sym_ok   = sym_ok;
    assign o_sts.len_zero = (len == '0);
    assign o_sts.walk_end = r_pv && (is_last || ((r_op == OP_FIND) && hit));
    assign o_sts.clr_last = (r_issue == CNT_W'(MAX_SYMBOLS - 1));

    // single write port shared by clear sweep, mark, increment and walk
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_issue[IDX_W-1:0];
        wr_data = '0;
        if (i_ctl.clr) begin
            wr_en = 1'b1;
        end else if (i_ctl.decode && (r_op == OP_MARK) && sym_ok) begin
            wr_en   = 1'b1;
            wr_addr = sym_idx;
            wr_data = COUNT_WIDTH'(1);
        end else if (i_ctl.inc_wr && !cnt_full) begin
            wr_en   = 1'b1;
            wr_addr = sym_idx;
            wr_data = r_rd_data + COUNT_WIDTH'(1);
        end else if (i_ctl.walk && r_pv &&
                     (((r_op == OP_RESCALE) && !rd_zero) || (r_op == OP_FILL))) begin
            wr_en   = 1'b1;
            wr_addr = r_pidx;
            wr_data = COUNT_WIDTH'(1);
        end
    end

    assign rd_addr = i_ctl.decode ? sym_idx : r_issue[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
            r_pv    <= 1'b0;
            r_alpha <= ALPHA_RESET;
            r_total <= '0;
        end else begin
            if (i_cfg_we) begin
                r_alpha <= i_cfg_data;
            end
            if (i_ctl.clr) begin
                r_issue <= r_issue + CNT_W'(1);
            end
            if (i_ctl.decode) begin
                r_issue <= '0;
                r_pv    <= 1'b0;
                case (r_op)
                    OP_FILL:             r_total <= SUM_W'(eff);
                    OP_RESCALE, OP_CLEAR: r_total <= '0;
                    OP_MARK: begin
                        if (sym_ok) begin
                            r_total <= total_inc;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_ctl.walk) begin
                if (issuing) begin
                    r_issue <= r_issue + CNT_W'(1);
                end
                r_pv <= issuing;
                // rescale: total is rebuilt as the number of nonzero counts
                if (r_pv && (r_op == OP_RESCALE) && !rd_zero) begin
                    r_total <= r_total + SUM_W'(1);
                end
            end
            if (i_ctl.inc_wr && !cnt_full) begin
                r_total <= total_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_op     <= t_op'(i_command);
            r_sym    <= i_symbol;
            r_target <= i_target;
        end
        if (i_ctl.decode) begin
            r_acc   <= '0;
            r_cl    <= '0;
            r_ch    <= '0;
            r_err   <= !sym_ok && (r_op inside {OP_INC, OP_QUERY, OP_MARK});
            r_found <= (r_op == OP_FIND) ? eff_l[FOUND_W-1:0] : '0;
            r_ones  <= (r_op == OP_CHECK);
        end
        if (i_ctl.walk) begin
            r_pidx <= r_issue[IDX_W-1:0];
            if (r_pv) begin
                case (r_op)
                    OP_QUERY: begin
                        if (is_last) begin
                            r_cl <= sat_sum(acc_hi);
                            r_ch <= sat_sum(hi);
                        end else begin
                            r_acc <= hi_cap;
                        end
                    end
                    OP_FIND: begin
                        if (hit) begin
                            r_found <= pidx_l[FOUND_W-1:0];
                        end else begin
                            r_acc <= hi_cap;
                        end
                    end
                    OP_CHECK: begin
                        if (r_rd_data != COUNT_WIDTH'(1)) begin
                            r_ones <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (i_ctl.done_load) begin
            r_o_cl    <= r_cl;
            r_o_ch    <= r_ch;
            r_o_total <= r_total;
            r_o_found <= r_found;
            r_o_ones  <= r_ones;
            r_o_err   <= r_err;
        end
    end

    assign o_cum_low      = r_o_cl;
    assign o_cum_high     = r_o_ch;
    assign o_total        = r_o_total;
    assign o_found_symbol = r_o_found;
    assign o_all_ones     = r_o_ones;
    assign o_error        = r_o_err;

endmodule

### src/adaptive_frequency_model.sv
// ----------------------------------------------------------------------------
// adaptive_frequency_model: adaptive symbol frequency table
// Commands: inc is a read-modify-write of one count; query/find/rescale/fill/check walk the
// table and clear sweeps all of it. One command at a time: o_ready is high only when idle.
// Reset: synchronous; a clearing pass over every table entry runs with o_ready low.
// ----------------------------------------------------------------------------
`include "adaptive_frequency_model_macros.svh"

module adaptive_frequency_model
    import afm_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_command,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic [SUM_W-1:0]   i_target,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SUM_W-1:0]   o_cum_low,
    output logic [SUM_W-1:0]   o_cum_high,
    output logic [SUM_W-1:0]   o_total,
    output logic [FOUND_W-1:0] o_found_symbol,
    output logic               o_all_ones,
    output logic               o_error,
    input  logic               i_cfg_we,
    input  logic [ALPHA_W-1:0] i_cfg_data
);

    t_ctl ctl;
    t_sts sts;
    logic err_payload;

    afm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    afm_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_command      (i_command),
        .i_symbol       (i_symbol),
        .i_target       (i_target),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_cum_low      (o_cum_low),
        .o_cum_high     (o_cum_high),
        .o_total        (o_total),
        .o_found_symbol (o_found_symbol),
        .o_all_ones     (o_all_ones),
        .o_error        (o_error)
    );

    assign err_payload = (|o_cum_low) || (|o_cum_high) || o_all_ones;

    `AFM_ASSERT_IMPL(a_cum_order, o_valid, o_cum_low <= o_cum_high, "cum_low above cum_high")
    `AFM_ASSERT_IMPL(a_err_clean, o_valid && o_error, !err_payload, "error result carries data")
    `AFM_ASSERT_IMPL(a_found_range, o_valid, o_found_symbol <= 9'd256, "found symbol out of range")
    `AFM_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready held after accept")

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: adaptive frequency table testbench
// Command transactions go in with random source gaps and sink stalls. A
// scoreboard keeps its own copy of the count table, running total and
// alphabet size, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import afm_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int TABLE_DEPTH      = DEF_MAX_SYMBOLS;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int NUM_PHASES       = 8;

    typedef struct {
        logic [SUM_W-1:0]   cum_low;
        logic [SUM_W-1:0]   cum_high;
        logic [SUM_W-1:0]   total;
        logic [FOUND_W-1:0] found;
        logic               all_ones;
        logic               error;
    } t_freq_result;

    class t_freq_scoreboard;
        logic [DEF_COUNT_WIDTH-1:0] counts [TABLE_DEPTH];
        logic [SUM_W-1:0]           run_total;
        logic [ALPHA_W-1:0]         alpha;
        t_freq_result               expected_q [$];
        int unsigned                errors;

        function new();
            foreach (counts[i]) counts[i] = '0;
            run_total = '0;
            alpha     = ALPHA_RESET;
            errors    = 0;
        endfunction

        function void set_size(logic [ALPHA_W-1:0] n);
            alpha = n;
        endfunction

        function int unsigned eff_size();
            return (alpha < TABLE_DEPTH) ? alpha : TABLE_DEPTH;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function logic [SUM_W-1:0] clip_sum(longint unsigned v);
            return (v > 64'hFFFF_FFFF) ? '1 : v[SUM_W-1:0];
        endfunction

        function void bump_total();
            if (run_total != '1) run_total++;
        endfunction

        // Apply one command to the table and queue the result it must produce.
        function void note_command(t_op cmd, logic [SYM_W-1:0] sym, logic [SUM_W-1:0] tgt);
            t_freq_result    r;
            int unsigned     size;
            longint unsigned acc;
            longint unsigned hi;
            bit              hit;
            size       = eff_size();
            r.cum_low  = '0;
            r.cum_high = '0;
            r.found    = '0;
            r.all_ones = 1'b0;
            r.error    = 1'b0;
            acc        = 0;
            hit        = 1'b0;
            case (cmd)
                OP_INC: begin
                    if (sym >= size) begin
                        r.error = 1'b1;
                    end else if (counts[sym] != '1) begin
                        counts[sym]++;
                        bump_total();
                    end
                end
                OP_QUERY: begin
                    if (sym >= size) begin
                        r.error = 1'b1;
                    end else begin
                        for (int i = 0; i < sym; i++) acc += counts[i];
                        hi = acc + counts[sym];
                        r.cum_low  = clip_sum(acc);
                        r.cum_high = clip_sum(hi);
                    end
                end
                OP_FIND: begin
                    r.found = FOUND_W'(size);
                    for (int i = 0; i < size && !hit; i++) begin
                        hi = acc + counts[i];
                        if (acc <= tgt && tgt <= hi) begin
                            r.found = FOUND_W'(i);
                            hit     = 1'b1;
                        end
                        acc = hi;
                    end
                end
                OP_RESCALE: begin
                    for (int i = 0; i < size; i++) begin
                        if (counts[i] != '0) begin
                            counts[i] = 1;
                            acc++;
                        end
                    end
                    run_total = clip_sum(acc);
                end
                OP_FILL: begin
                    for (int i = 0; i < size; i++) counts[i] = 1;
                    run_total = SUM_W'(size);
                end
                OP_CLEAR: begin
                    foreach (counts[i]) counts[i] = '0;
                    run_total = '0;
                end
                OP_MARK: begin
                    if (sym >= size) begin
                        r.error = 1'b1;
                    end else begin
                        counts[sym] = 1;
                        bump_total();
                    end
                end
                default: begin
                    r.all_ones = 1'b1;
                    for (int i = 0; i < size; i++)
                        if (counts[i] != 1) r.all_ones = 1'b0;
                end
            endcase
            r.total = run_total;
            expected_q.push_back(r);
        endfunction

        task report(string what);
            $display("tb_top: mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(t_freq_result got);
            t_freq_result want;
            if (expected_q.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.cum_low !== want.cum_low)
                report($sformatf("cum_low %h, expected %h", got.cum_low, want.cum_low));
            if (got.cum_high !== want.cum_high)
                report($sformatf("cum_high %h, expected %h", got.cum_high, want.cum_high));
            if (got.total !== want.total)
                report($sformatf("total %h, expected %h", got.total, want.total));
            if (got.found !== want.found)
                report($sformatf("found_symbol %0d, expected %0d", got.found, want.found));
            if (got.all_ones !== want.all_ones)
                report($sformatf("all_ones %b, expected %b", got.all_ones, want.all_ones));
            if (got.error !== want.error)
                report($sformatf("error %b, expected %b", got.error, want.error));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [OP_W-1:0]    i_command;
    logic [SYM_W-1:0]   i_symbol;
    logic [SUM_W-1:0]   i_target;
    logic               o_valid;
    logic               i_ready;
    logic [SUM_W-1:0]   o_cum_low;
    logic [SUM_W-1:0]   o_cum_high;
    logic [SUM_W-1:0]   o_total;
    logic [FOUND_W-1:0] o_found_symbol;
    logic               o_all_ones;
    logic               o_error;
    logic               i_cfg_we;
    logic [ALPHA_W-1:0] i_cfg_data;

    t_freq_scoreboard freq_sb = new();
    t_freq_result     sampled;
    int unsigned      quiet_cycles = 0;
    bit               src_idle;
    bit               snk_idle;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    adaptive_frequency_model dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_symbol       (i_symbol),
        .i_target       (i_target),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cum_low      (o_cum_low),
        .o_cum_high     (o_cum_high),
        .o_total        (o_total),
        .o_found_symbol (o_found_symbol),
        .o_all_ones     (o_all_ones),
        .o_error        (o_error),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    // Result check comes before the new command is noted, so the queue order
    // holds when a result leaves on the same edge as the next command enters.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sampled.cum_low  = o_cum_low;
                sampled.cum_high = o_cum_high;
                sampled.total    = o_total;
                sampled.found    = o_found_symbol;
                sampled.all_ones = o_all_ones;
                sampled.error    = o_error;
                freq_sb.check_result(sampled);
            end
            if (i_valid && o_ready)
                freq_sb.note_command(t_op'(i_command), i_symbol, i_target);
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb_top: no transaction for %0d cycles", WATCHDOG_LIMIT);
                    $display("tb_top: done, errors");
                    $finish;
                end
            end
        end
    end

    // Result sink: random stall before each result when enabled.
    initial begin : result_sink
        int unsigned gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = snk_idle ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Returns right after the edge that accepts the command; valid stays high.
    task automatic send_item(input t_op cmd, input logic [SYM_W-1:0] sym,
                             input logic [SUM_W-1:0] tgt);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command <= cmd;
        i_symbol  <= sym;
        i_target  <= tgt;
        i_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (freq_sb.pending() != 0 || !o_ready) @(posedge i_clk);
    endtask

    task automatic set_alphabet(input logic [ALPHA_W-1:0] n);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        freq_sb.set_size(n);
    endtask

    task automatic random_items(input int unsigned n);
        int unsigned      pick;
        int unsigned      size;
        logic [SUM_W-1:0] tot;
        logic [SYM_W-1:0] sym;
        logic [SUM_W-1:0] tgt;
        t_op              cmd;
        repeat (n) begin
            size = freq_sb.eff_size();
            tot  = freq_sb.run_total;
            pick = $urandom_range(0, 99);
            if (pick < 32)      cmd = OP_INC;
            else if (pick < 46) cmd = OP_QUERY;
            else if (pick < 64) cmd = OP_FIND;
            else if (pick < 67) cmd = OP_RESCALE;
            else if (pick < 69) cmd = OP_FILL;
            else if (pick < 71) cmd = OP_CLEAR;
            else if (pick < 86) cmd = OP_MARK;
            else                cmd = OP_CHECK;
            if (size != 0 && $urandom_range(0, 99) < 85)
                sym = SYM_W'($urandom_range(0, size - 1));
            else
                sym = SYM_W'($urandom_range(0, 255));
            // mostly targets that land inside the cumulative range
            pick = $urandom_range(0, 99);
            if (pick < 70)
                tgt = $urandom_range(0, (tot > 32'hFFFF_FFF0) ? tot : tot + 2);
            else if (pick < 85)
                tgt = $urandom;
            else
                tgt = 32'hFFFF_FFFF - $urandom_range(0, 3);
            send_item(cmd, sym, tgt);
        end
    endtask

    initial begin : stimulus
        logic [ALPHA_W-1:0] phase_size [NUM_PHASES];
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_command  = OP_INC;
        i_symbol   = '0;
        i_target   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        src_idle   = 1'b1;
        snk_idle   = 1'b1;
        phase_size = '{9'd511, 9'd1, 9'd2, 9'd17, 9'd0, 9'd0, 9'd255, 9'd256};
        phase_size[5] = ALPHA_W'($urandom_range(3, 254));
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full table: empty-table find, inc at both ends, double mark, whole-table ops
        set_alphabet(9'd256);
        send_item(OP_CHECK,   8'd0,   32'd0);
        send_item(OP_FIND,    8'd0,   32'd0);
        send_item(OP_FIND,    8'd0,   32'hFFFF_FFFF);
        send_item(OP_INC,     8'd0,   32'd0);
        send_item(OP_INC,     8'd255, 32'd0);
        send_item(OP_INC,     8'd255, 32'd0);
        send_item(OP_QUERY,   8'd255, 32'd0);
        send_item(OP_QUERY,   8'd0,   32'd0);
        send_item(OP_MARK,    8'd5,   32'd0);
        send_item(OP_MARK,    8'd5,   32'd0);
        send_item(OP_FIND,    8'd0,   32'd1);
        send_item(OP_RESCALE, 8'd0,   32'd0);
        send_item(OP_CHECK,   8'd0,   32'd0);
        send_item(OP_FILL,    8'd0,   32'd0);
        send_item(OP_CHECK,   8'd0,   32'd0);
        send_item(OP_QUERY,   8'd255, 32'hFFFF_FFFF);
        send_item(OP_CLEAR,   8'd0,   32'd0);

        // size zero: everything is out of range, find gives 0, check gives 1
        set_alphabet(9'd0);
        send_item(OP_INC,     8'd0,   32'd0);
        send_item(OP_QUERY,   8'd3,   32'd0);
        send_item(OP_MARK,    8'd1,   32'd0);
        send_item(OP_FIND,    8'd0,   32'd5);
        send_item(OP_CHECK,   8'd0,   32'd0);
        send_item(OP_FILL,    8'd0,   32'd0);
        send_item(OP_RESCALE, 8'd0,   32'd0);

        set_alphabet(9'd2);
        send_item(OP_INC,     8'd1,   32'd0);
        send_item(OP_INC,     8'd7,   32'd0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_alphabet(phase_size[p]);
            src_idle = p[0];
            snk_idle = p[1];
            random_items(RANDOM_PER_PHASE);
        end

        drain();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (freq_sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

### adaptive_frequency_model.f
+incdir+src
src/afm_pkg.sv
src/afm_ctrl.sv
src/afm_datapath.sv
src/adaptive_frequency_model.sv
test/tb_top.sv
